@@ sv/acpu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package acpu_pkg;

  localparam int MEM_DEPTH = 256;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = $clog2(MEM_DEPTH);
  localparam int PC_BITS   = ADDR_BITS + 1;
  localparam int KIND_BITS = 2;
  localparam int STAT_BITS = 2;
  localparam int UPC_BITS  = 5;

  localparam int IN_RAW_BITS    = ADDR_BITS + WORD_BITS;
  localparam int IN_TDATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS   = PC_BITS + 2 * WORD_BITS + STAT_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic [PC_BITS-1:0] PC_LIMIT       = PC_BITS'(MEM_DEPTH);
  localparam logic [PC_BITS-1:0] CODE_LIMIT_RST = PC_BITS'(MEM_DEPTH);

  // item kinds
  localparam logic [KIND_BITS-1:0] K_LOAD    = 2'd0;
  localparam logic [KIND_BITS-1:0] K_EXEC    = 2'd1;
  localparam logic [KIND_BITS-1:0] K_RESTART = 2'd2;

  // run status
  localparam logic [STAT_BITS-1:0] STAT_RUN   = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_STOP  = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_FAULT = 2'd2;
  localparam logic [STAT_BITS-1:0] STAT_DIVZ  = 2'd3;

  // instruction opcodes
  localparam logic [WORD_BITS-1:0] OP_ADD  = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] OP_SUB  = WORD_BITS'(2);
  localparam logic [WORD_BITS-1:0] OP_MUL  = WORD_BITS'(3);
  localparam logic [WORD_BITS-1:0] OP_DIV  = WORD_BITS'(4);
  localparam logic [WORD_BITS-1:0] OP_JMP  = WORD_BITS'(5);
  localparam logic [WORD_BITS-1:0] OP_JMPN = WORD_BITS'(6);
  localparam logic [WORD_BITS-1:0] OP_JMPP = WORD_BITS'(7);
  localparam logic [WORD_BITS-1:0] OP_JMPZ = WORD_BITS'(8);
  localparam logic [WORD_BITS-1:0] OP_COPY = WORD_BITS'(9);
  localparam logic [WORD_BITS-1:0] OP_LOAD = WORD_BITS'(10);
  localparam logic [WORD_BITS-1:0] OP_STOR = WORD_BITS'(11);
  localparam logic [WORD_BITS-1:0] OP_INP  = WORD_BITS'(12);
  localparam logic [WORD_BITS-1:0] OP_OUTP = WORD_BITS'(13);
  localparam logic [WORD_BITS-1:0] OP_STOP = WORD_BITS'(14);

  typedef enum logic [2:0] {A_PC, A_PC1, A_PC2, A_OP1, A_OP2, A_ITEM} asel_t;
  typedef enum logic [1:0] {W_ACC, W_VAL, W_DATA} wsel_t;
  typedef enum logic [2:0] {L_NONE, L_OP, L_OP1, L_OP2, L_DATA} lsel_t;
  typedef enum logic [2:0] {
    AC_HOLD, AC_ADD, AC_SUB, AC_MUL, AC_LOAD, AC_QUOT, AC_CLEAR
  } accop_t;
  typedef enum logic [2:0] {PC_HOLD, PC_ADV1, PC_ADV2, PC_ADV3, PC_JUMP, PC_CLEAR} pcop_t;
  typedef enum logic [1:0] {J_ALWAYS, J_NEG, J_POS, J_ZERO} jcond_t;
  typedef enum logic [2:0] {ST_HOLD, ST_STOP, ST_FAULT, ST_DIVZ, ST_CLEAR} stop_t;
  typedef enum logic [2:0] {
    SQ_NEXT, SQ_GOTO, SQ_KIND, SQ_OPC, SQ_FAULT, SQ_DIVZ, SQ_DIVW, SQ_EMIT
  } seq_t;

  // one microcode word
  typedef struct packed {
    logic                idle;
    asel_t               asel;
    logic                we;
    wsel_t               wsel;
    lsel_t               lat;
    accop_t              acc;
    pcop_t               pc;
    jcond_t              jc;
    stop_t               st;
    logic                outp;
    logic                dstart;
    seq_t                seq;
    logic [UPC_BITS-1:0] tgt;
  } ctl_t;

  // branch conditions seen by the sequencer
  typedef struct packed {
    logic                 fire;
    logic [KIND_BITS-1:0] kind;
    logic                 run_ok;
    logic                 fault;
    logic                 divz;
    logic                 div_busy;
    logic                 out_free;
    logic [WORD_BITS-1:0] op;
  } cond_t;

endpackage

`default_nettype wire

@@ sv/accumulator_cpu_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One item in flight at a time; a microprogram steps the datapath through the one memory port.
// Execute item: fetch, run the opcode's handler, emit; a divide waits on the bit-serial divider.
// Load and restart items, execute while stopped and fetch faults also end by emitting a result.
// A new item is taken while the previous result still waits in the output register.
// Synchronous active-low reset clears pc, acc, status, code_limit (256) and the sequencer.

module accumulator_cpu_step
  import acpu_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // cfg: code_limit
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [PC_BITS-1:0]        cfg_data,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // address, value
  input  wire logic [IN_TDATA_BITS-1:0]  in_tdata,
  // kind
  input  wire logic [KIND_BITS-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // pc_value, acc_value, out_value, status, zero fill
  output logic      [OUT_TDATA_BITS-1:0] out_tdata,
  // out_valid
  output logic      [0:0]                out_tuser
);

  ctl_t  ctl;
  cond_t cond;

  logic [PC_BITS-1:0]   code_limit_r;
  logic [PC_BITS-1:0]   pc_r;
  logic [WORD_BITS-1:0] acc_r;
  logic [STAT_BITS-1:0] st_r;
  logic [PC_BITS-1:0]   shown_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [WORD_BITS-1:0] val_r;
  logic [WORD_BITS-1:0] op_r;
  logic [WORD_BITS-1:0] op1_r;
  logic [WORD_BITS-1:0] op2_r;
  logic [WORD_BITS-1:0] data_r;
  logic                 ov_r;
  logic [WORD_BITS-1:0] oval_r;

  logic                      out_tvalid_r;
  logic [OUT_TDATA_BITS-1:0] out_tdata_r;
  logic [0:0]                out_tuser_r;

  logic                 in_fire;
  logic                 out_free;
  logic                 emit;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 div_busy;
  logic [WORD_BITS-1:0] div_q;
  logic                 div_start;
  logic [WORD_BITS-1:0] mul_lo;
  logic                 acc_neg;
  logic                 acc_zero;
  logic                 take_jump;
  logic [PC_BITS-1:0]   pc_inc;
  logic [PC_BITS-1:0]   pc_sum;
  logic [PC_BITS-1:0]   pc_adv;
  logic [PC_BITS-1:0]   pc_jump;

  assign cfg_ready = 1'b1;
  assign in_tready = ctl.idle;
  assign in_fire   = in_tvalid && ctl.idle;
  assign out_free  = !out_tvalid_r || out_tready;
  assign emit      = (ctl.seq == SQ_EMIT) && out_free;

  assign cond.fire     = in_fire;
  assign cond.kind     = in_tuser;
  assign cond.run_ok   = st_r == STAT_RUN;
  assign cond.fault    = (pc_r >= code_limit_r) || (pc_r >= PC_LIMIT);
  assign cond.divz     = data_r == '0;
  assign cond.div_busy = div_busy;
  assign cond.out_free = out_free;
  assign cond.op       = op_r;

  acpu_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctl   (ctl)
  );

  always_comb begin
    unique case (ctl.asel)
      A_PC:    ram_addr = pc_r[ADDR_BITS-1:0];
      A_PC1:   ram_addr = pc_r[ADDR_BITS-1:0] + ADDR_BITS'(1);
      A_PC2:   ram_addr = pc_r[ADDR_BITS-1:0] + ADDR_BITS'(2);
      A_OP1:   ram_addr = op1_r[ADDR_BITS-1:0];
      A_OP2:   ram_addr = op2_r[ADDR_BITS-1:0];
      A_ITEM:  ram_addr = addr_r;
      default: ram_addr = pc_r[ADDR_BITS-1:0];
    endcase
  end

  always_comb begin
    unique case (ctl.wsel)
      W_ACC:   ram_wdata = acc_r;
      W_VAL:   ram_wdata = val_r;
      W_DATA:  ram_wdata = data_r;
      default: ram_wdata = acc_r;
    endcase
  end

  acpu_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign div_start = ctl.dstart && !cond.divz;

  acpu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (data_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign mul_lo   = acc_r * data_r;
  assign acc_neg  = acc_r[WORD_BITS-1];
  assign acc_zero = acc_r == '0;

  always_comb begin
    unique case (ctl.jc)
      J_ALWAYS: take_jump = 1'b1;
      J_NEG:    take_jump = acc_neg;
      J_POS:    take_jump = !acc_neg && !acc_zero;
      J_ZERO:   take_jump = acc_zero;
      default:  take_jump = 1'b0;
    endcase
  end

  // pc is below MEM_DEPTH whenever it advances, so the sum cannot wrap
  always_comb begin
    unique case (ctl.pc)
      PC_ADV1: pc_inc = PC_BITS'(1);
      PC_ADV3: pc_inc = PC_BITS'(3);
      default: pc_inc = PC_BITS'(2);
    endcase
  end

  assign pc_sum  = pc_r + pc_inc;
  assign pc_adv  = (pc_sum > PC_LIMIT) ? PC_LIMIT : pc_sum;
  assign pc_jump = (|op1_r[WORD_BITS-1:ADDR_BITS]) ? PC_LIMIT
                                                   : {1'b0, op1_r[ADDR_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_limit_r <= CODE_LIMIT_RST;
      pc_r         <= '0;
      acc_r        <= '0;
      st_r         <= STAT_RUN;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        code_limit_r <= cfg_data;
      end

      unique case (ctl.acc)
        AC_ADD:   acc_r <= acc_r + data_r;
        AC_SUB:   acc_r <= acc_r - data_r;
        AC_MUL:   acc_r <= mul_lo;
        AC_LOAD:  acc_r <= data_r;
        AC_QUOT:  acc_r <= div_q;
        AC_CLEAR: acc_r <= '0;
        default:  acc_r <= acc_r;
      endcase

      unique case (ctl.pc)
        PC_ADV1, PC_ADV2, PC_ADV3: pc_r <= pc_adv;
        PC_JUMP:  pc_r <= take_jump ? pc_jump : pc_adv;
        PC_CLEAR: pc_r <= '0;
        default:  pc_r <= pc_r;
      endcase

      unique case (ctl.st)
        ST_STOP:  st_r <= STAT_STOP;
        ST_FAULT: st_r <= STAT_FAULT;
        ST_DIVZ:  st_r <= STAT_DIVZ;
        ST_CLEAR: st_r <= STAT_RUN;
        default:  st_r <= st_r;
      endcase

      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r  <= in_tdata[ADDR_BITS-1:0];
      val_r   <= in_tdata[ADDR_BITS +: WORD_BITS];
      shown_r <= pc_r;
      ov_r    <= 1'b0;
      oval_r  <= '0;
    end else begin
      if (ctl.pc == PC_CLEAR) begin
        shown_r <= '0;
      end
      if (ctl.outp) begin
        ov_r   <= 1'b1;
        oval_r <= data_r;
      end
    end

    unique case (ctl.lat)
      L_OP:    op_r   <= ram_rdata;
      L_OP1:   op1_r  <= ram_rdata;
      L_OP2:   op2_r  <= ram_rdata;
      L_DATA:  data_r <= ram_rdata;
      default: ;
    endcase

    if (emit) begin
      out_tdata_r <= OUT_TDATA_BITS'({st_r, oval_r, acc_r, shown_r});
      out_tuser_r <= ov_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

@@ sv/acpu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ sv/acpu_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acpu_div
  import acpu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] dividend,
  input  wire logic [WORD_BITS-1:0] divisor,
  output logic                      busy,
  output logic      [WORD_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(WORD_BITS + 1);

  logic [CNT_BITS-1:0]  cnt_r;
  logic [WORD_BITS-1:0] quo_r;
  logic [WORD_BITS-1:0] rem_r;
  logic [WORD_BITS-1:0] mb_r;
  logic                 neg_r;

  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   diff;
  logic                 ge;

  // restoring divide on magnitudes, one quotient bit per cycle
  assign shifted = {rem_r, quo_r[WORD_BITS-1]};
  assign diff    = shifted - {1'b0, mb_r};
  assign ge      = shifted >= {1'b0, mb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_BITS'(WORD_BITS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[WORD_BITS-1] ? ('0 - dividend) : dividend;
      mb_r  <= divisor[WORD_BITS-1] ? ('0 - divisor) : divisor;
      neg_r <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[WORD_BITS-2:0], ge};
      rem_r <= ge ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
    end
  end

  assign busy     = cnt_r != '0;
  assign quotient = neg_r ? ('0 - quo_r) : quo_r;

endmodule

`default_nettype wire

@@ sv/acpu_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acpu_seq
  import acpu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cond_t cond,
  output ctl_t       ctl
);

  localparam logic [UPC_BITS-1:0] U_IDLE    = 5'd0;
  localparam logic [UPC_BITS-1:0] U_LOAD    = 5'd1;
  localparam logic [UPC_BITS-1:0] U_RESTART = 5'd2;
  localparam logic [UPC_BITS-1:0] U_FETCH   = 5'd3;
  localparam logic [UPC_BITS-1:0] U_F1      = 5'd4;
  localparam logic [UPC_BITS-1:0] U_F2      = 5'd5;
  localparam logic [UPC_BITS-1:0] U_F3      = 5'd6;
  localparam logic [UPC_BITS-1:0] U_F4      = 5'd7;
  localparam logic [UPC_BITS-1:0] U_ADD     = 5'd8;
  localparam logic [UPC_BITS-1:0] U_SUB     = 5'd9;
  localparam logic [UPC_BITS-1:0] U_MUL     = 5'd10;
  localparam logic [UPC_BITS-1:0] U_DIV     = 5'd11;
  localparam logic [UPC_BITS-1:0] U_DIVW    = 5'd12;
  localparam logic [UPC_BITS-1:0] U_DIVQ    = 5'd13;
  localparam logic [UPC_BITS-1:0] U_DIVZ    = 5'd14;
  localparam logic [UPC_BITS-1:0] U_JMP     = 5'd15;
  localparam logic [UPC_BITS-1:0] U_JMPN    = 5'd16;
  localparam logic [UPC_BITS-1:0] U_JMPP    = 5'd17;
  localparam logic [UPC_BITS-1:0] U_JMPZ    = 5'd18;
  localparam logic [UPC_BITS-1:0] U_COPY    = 5'd19;
  localparam logic [UPC_BITS-1:0] U_LDA     = 5'd20;
  localparam logic [UPC_BITS-1:0] U_STA     = 5'd21;
  localparam logic [UPC_BITS-1:0] U_INP     = 5'd22;
  localparam logic [UPC_BITS-1:0] U_OUTP    = 5'd23;
  localparam logic [UPC_BITS-1:0] U_STOP    = 5'd24;
  localparam logic [UPC_BITS-1:0] U_NOP     = 5'd25;
  localparam logic [UPC_BITS-1:0] U_FAULT   = 5'd26;
  localparam logic [UPC_BITS-1:0] U_EMIT    = 5'd27;

  // control store
  function automatic ctl_t uword(input logic [UPC_BITS-1:0] a);
    ctl_t w;
    w     = '0;
    w.seq = SQ_GOTO;
    w.tgt = U_EMIT;
    unique case (a)
      U_IDLE: begin
        w.idle = 1'b1;
        w.seq  = SQ_KIND;
      end
      U_LOAD: begin
        w.asel = A_ITEM;
        w.we   = 1'b1;
        w.wsel = W_VAL;
      end
      U_RESTART: begin
        w.acc = AC_CLEAR;
        w.pc  = PC_CLEAR;
        w.st  = ST_CLEAR;
      end
      U_FETCH: begin
        w.asel = A_PC;
        w.seq  = SQ_FAULT;
        w.tgt  = U_FAULT;
      end
      U_F1: begin
        w.asel = A_PC1;
        w.lat  = L_OP;
        w.seq  = SQ_NEXT;
      end
      U_F2: begin
        w.asel = A_PC2;
        w.lat  = L_OP1;
        w.seq  = SQ_NEXT;
      end
      U_F3: begin
        w.asel = A_OP1;
        w.lat  = L_OP2;
        w.seq  = SQ_NEXT;
      end
      U_F4: begin
        w.lat = L_DATA;
        w.seq = SQ_OPC;
      end
      U_ADD: begin
        w.acc = AC_ADD;
        w.pc  = PC_ADV2;
      end
      U_SUB: begin
        w.acc = AC_SUB;
        w.pc  = PC_ADV2;
      end
      U_MUL: begin
        w.acc = AC_MUL;
        w.pc  = PC_ADV2;
      end
      U_DIV: begin
        w.dstart = 1'b1;
        w.seq    = SQ_DIVZ;
        w.tgt    = U_DIVZ;
      end
      U_DIVW: begin
        w.seq = SQ_DIVW;
      end
      U_DIVQ: begin
        w.acc = AC_QUOT;
        w.pc  = PC_ADV2;
      end
      U_DIVZ: begin
        w.st = ST_DIVZ;
      end
      U_JMP: begin
        w.pc = PC_JUMP;
        w.jc = J_ALWAYS;
      end
      U_JMPN: begin
        w.pc = PC_JUMP;
        w.jc = J_NEG;
      end
      U_JMPP: begin
        w.pc = PC_JUMP;
        w.jc = J_POS;
      end
      U_JMPZ: begin
        w.pc = PC_JUMP;
        w.jc = J_ZERO;
      end
      U_COPY: begin
        w.asel = A_OP2;
        w.we   = 1'b1;
        w.wsel = W_DATA;
        w.pc   = PC_ADV3;
      end
      U_LDA: begin
        w.acc = AC_LOAD;
        w.pc  = PC_ADV2;
      end
      U_STA: begin
        w.asel = A_OP1;
        w.we   = 1'b1;
        w.wsel = W_ACC;
        w.pc   = PC_ADV2;
      end
      U_INP: begin
        w.asel = A_OP1;
        w.we   = 1'b1;
        w.wsel = W_VAL;
        w.pc   = PC_ADV2;
      end
      U_OUTP: begin
        w.outp = 1'b1;
        w.pc   = PC_ADV2;
      end
      U_STOP: begin
        w.st = ST_STOP;
      end
      U_NOP: begin
        w.pc = PC_ADV1;
      end
      U_FAULT: begin
        w.st = ST_FAULT;
      end
      U_EMIT: begin
        w.seq = SQ_EMIT;
        w.tgt = U_IDLE;
      end
      default: begin
        w.tgt = U_IDLE;
      end
    endcase
    return w;
  endfunction

  // opcode to handler entry
  function automatic logic [UPC_BITS-1:0] op_entry(input logic [WORD_BITS-1:0] op);
    logic [UPC_BITS-1:0] e;
    unique case (op)
      OP_ADD:  e = U_ADD;
      OP_SUB:  e = U_SUB;
      OP_MUL:  e = U_MUL;
      OP_DIV:  e = U_DIV;
      OP_JMP:  e = U_JMP;
      OP_JMPN: e = U_JMPN;
      OP_JMPP: e = U_JMPP;
      OP_JMPZ: e = U_JMPZ;
      OP_COPY: e = U_COPY;
      OP_LOAD: e = U_LDA;
      OP_STOR: e = U_STA;
      OP_INP:  e = U_INP;
      OP_OUTP: e = U_OUTP;
      OP_STOP: e = U_STOP;
      default: e = U_NOP;
    endcase
    return e;
  endfunction

  logic [UPC_BITS-1:0] upc_r;
  logic [UPC_BITS-1:0] upc_nxt;
  logic [UPC_BITS-1:0] upc_inc;

  assign ctl     = uword(upc_r);
  assign upc_inc = upc_r + 1'b1;

  always_comb begin
    upc_nxt = upc_r;
    unique case (ctl.seq)
      SQ_NEXT:  upc_nxt = upc_inc;
      SQ_GOTO:  upc_nxt = ctl.tgt;
      SQ_KIND: begin
        if (cond.fire) begin
          unique case (cond.kind)
            K_LOAD:    upc_nxt = U_LOAD;
            K_EXEC:    upc_nxt = cond.run_ok ? U_FETCH : U_EMIT;
            K_RESTART: upc_nxt = U_RESTART;
            default:   upc_nxt = U_EMIT;
          endcase
        end
      end
      SQ_OPC:   upc_nxt = op_entry(cond.op);
      SQ_FAULT: upc_nxt = cond.fault ? ctl.tgt : upc_inc;
      SQ_DIVZ:  upc_nxt = cond.divz ? ctl.tgt : upc_inc;
      SQ_DIVW:  upc_nxt = cond.div_busy ? upc_r : upc_inc;
      SQ_EMIT:  upc_nxt = cond.out_free ? ctl.tgt : upc_r;
      default:  upc_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire
